/* hw/rtl/mmec_pkg.sv */
// shared types, constants and controller/datapath interface structs for the matrix multiply block
`default_nettype none

package mmec_pkg;

  // default edge length of the square cell stores
  localparam int unsigned MAX_DIM_DEF = 16;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned DIM_W    = 5;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned STAT_W   = 2;

  // empty cell marker (-999)
  localparam logic [VAL_W-1:0] CELL_EMPTY = 32'hFFFF_FC19;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_WR_A  = 2'd0,
    KIND_WR_B  = 2'd1,
    KIND_PROD  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RUN,
    S_DRAIN,
    S_RESULT
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic write;
    logic issue;
    logic clr_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    kind_e kind;
    logic  skip;
    logic  last_issue;
    logic  pipe_busy;
    logic  clr_last;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/mmec_ctrl.sv */
// controller state machine sequencing writes, clear sweeps and product requests
`default_nettype none

module mmec_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mmec_pkg::dp_stat_t   stat_i,
  output mmec_pkg::ctrl_cmd_t  cmd_o
);

  mmec_pkg::ctrl_state_e state_q, state_d;

  // state register, reset starts with a clear sweep of both stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmec_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mmec_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = mmec_pkg::S_IDLE;
        end
      end
      mmec_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = mmec_pkg::S_DECODE;
        end
      end
      mmec_pkg::S_DECODE: begin
        case (stat_i.kind)
          mmec_pkg::KIND_WR_A, mmec_pkg::KIND_WR_B: begin
            cmd_o.write = 1'b1;
            state_d     = mmec_pkg::S_IDLE;
          end
          mmec_pkg::KIND_CLEAR: begin
            state_d = mmec_pkg::S_CLEAR;
          end
          mmec_pkg::KIND_PROD: begin
            state_d = stat_i.skip ? mmec_pkg::S_RESULT : mmec_pkg::S_RUN;
          end
          default: begin
            state_d = mmec_pkg::S_IDLE;
          end
        endcase
      end
      mmec_pkg::S_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = mmec_pkg::S_DRAIN;
        end
      end
      mmec_pkg::S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = mmec_pkg::S_RESULT;
        end
      end
      mmec_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = mmec_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mmec_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mmec_dp.sv */
// datapath: config registers, cell stores, multiply-accumulate pipeline and output register
`default_nettype none

module mmec_dp #(
  parameter int unsigned MAX_DIM = mmec_pkg::MAX_DIM_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration writes
  input  wire                                cfg_we_i,
  input  wire  [mmec_pkg::CFG_IX_W-1:0]      cfg_idx_i,
  input  wire  [mmec_pkg::DIM_W-1:0]         cfg_data_i,
  // request payload
  input  wire  [mmec_pkg::KIND_W-1:0]        in_kind_i,
  input  wire  [mmec_pkg::IDX_W-1:0]         in_row_i,
  input  wire  [mmec_pkg::IDX_W-1:0]         in_col_i,
  input  wire  [mmec_pkg::VAL_W-1:0]         in_value_i,
  // controller link
  input  mmec_pkg::ctrl_cmd_t                cmd_i,
  output mmec_pkg::dp_stat_t                 stat_o,
  // result register
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic [mmec_pkg::IDX_W-1:0]         out_row_o,
  output logic [mmec_pkg::IDX_W-1:0]         out_col_o,
  output logic [mmec_pkg::VAL_W-1:0]         out_product_o,
  output logic                               out_empty_o,
  output logic [mmec_pkg::STAT_W-1:0]        out_status_o
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW     = $clog2(MAX_DIM + 1);

  // cell address from row and column, computed wide then narrowed
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] r, input logic [7:0] c);
    logic [15:0] t;
    t = 16'(r) * 16'(MAX_DIM) + 16'(c);
    return ADDR_W'(t);
  endfunction

  // dimension register limited to the store size
  function automatic logic [7:0] dim_clamp(input logic [mmec_pkg::DIM_W-1:0] d);
    return (8'(d) > 8'(MAX_DIM)) ? 8'(MAX_DIM) : 8'(d);
  endfunction

  // config registers
  logic [mmec_pkg::DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= '0;
      a_cols_q <= '0;
      b_rows_q <= '0;
      b_cols_q <= '0;
    end else if (cfg_we_i) begin
      case (mmec_pkg::cfg_idx_e'(cfg_idx_i))
        mmec_pkg::CFG_A_ROWS: a_rows_q <= cfg_data_i;
        mmec_pkg::CFG_A_COLS: a_cols_q <= cfg_data_i;
        mmec_pkg::CFG_B_ROWS: b_rows_q <= cfg_data_i;
        mmec_pkg::CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request capture
  mmec_pkg::kind_e             req_kind_q;
  logic [mmec_pkg::IDX_W-1:0]  req_row_q, req_col_q;
  logic [mmec_pkg::VAL_W-1:0]  req_value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_kind_q  <= mmec_pkg::kind_e'(in_kind_i);
      req_row_q   <= in_row_i;
      req_col_q   <= in_col_i;
      req_value_q <= in_value_i;
    end
  end

  // request checks
  logic          mismatch, out_range, wr_in_range;
  logic [KW-1:0] inner;

  always_comb begin
    mismatch    = (a_cols_q != b_rows_q);
    out_range   = (8'(req_row_q) >= dim_clamp(a_rows_q)) ||
                  (8'(req_col_q) >= dim_clamp(b_cols_q));
    inner       = KW'(dim_clamp(a_cols_q));
    wr_in_range = (8'(req_row_q) < 8'(MAX_DIM)) && (8'(req_col_q) < 8'(MAX_DIM));
  end

  // clear sweep address
  logic [ADDR_W-1:0] clr_q;
  logic              clr_last;

  assign clr_last = (clr_q == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_last ? '0 : clr_q + ADDR_W'(1);
    end
  end

  // inner index counter
  logic [KW-1:0] k_q;
  logic          last_issue;

  assign last_issue = ((k_q + KW'(1)) == inner);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.take) begin
      k_q <= '0;
    end else if (cmd_i.issue) begin
      k_q <= k_q + KW'(1);
    end
  end

  // store write port select
  logic                       we_a, we_b;
  logic [ADDR_W-1:0]          w_addr;
  logic [mmec_pkg::VAL_W-1:0] w_data;

  always_comb begin
    we_a   = cmd_i.clr_step ||
             (cmd_i.write && wr_in_range && (req_kind_q == mmec_pkg::KIND_WR_A));
    we_b   = cmd_i.clr_step ||
             (cmd_i.write && wr_in_range && (req_kind_q == mmec_pkg::KIND_WR_B));
    w_addr = cmd_i.clr_step ? clr_q : cell_addr(8'(req_row_q), 8'(req_col_q));
    w_data = cmd_i.clr_step ? mmec_pkg::CELL_EMPTY : req_value_q;
  end

  // cell stores
  logic [mmec_pkg::VAL_W-1:0] store_a [DEPTH];
  logic [mmec_pkg::VAL_W-1:0] store_b [DEPTH];
  logic [mmec_pkg::VAL_W-1:0] a_rd_q, b_rd_q;
  logic [ADDR_W-1:0]          ra_addr, rb_addr;

  assign ra_addr = cell_addr(8'(req_row_q), 8'(k_q));
  assign rb_addr = cell_addr(8'(k_q), 8'(req_col_q));

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      store_a[w_addr] <= w_data;
    end
    if (we_b) begin
      store_b[w_addr] <= w_data;
    end
  end

  // operand reads along row of a and column of b
  always_ff @(posedge clk_i) begin
    a_rd_q <= store_a[ra_addr];
    b_rd_q <= store_b[rb_addr];
  end

  // pipeline valid flags
  logic rd_vld_q, mul_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  // multiply stage with empty detection, then accumulate
  logic [mmec_pkg::VAL_W-1:0] prod_q, acc_q;
  logic                       empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      empty_q <= 1'b0;
    end else if (rd_vld_q &&
                 ((a_rd_q == mmec_pkg::CELL_EMPTY) || (b_rd_q == mmec_pkg::CELL_EMPTY))) begin
      empty_q <= 1'b1;
    end
    if (rd_vld_q) begin
      prod_q <= 32'(a_rd_q * b_rd_q);
    end
    if (cmd_i.take) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // output register
  logic out_valid_q;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_o     <= req_row_q;
      out_col_o     <= req_col_q;
      out_product_o <= empty_q ? mmec_pkg::CELL_EMPTY : acc_q;
      out_empty_o   <= empty_q;
      if (mismatch) begin
        out_status_o <= mmec_pkg::ST_MISMATCH;
      end else if (out_range) begin
        out_status_o <= mmec_pkg::ST_RANGE;
      end else begin
        out_status_o <= mmec_pkg::ST_OK;
      end
    end
  end

  // status to controller
  always_comb begin
    stat_o.kind       = req_kind_q;
    stat_o.skip       = mismatch || out_range || (inner == '0);
    stat_o.last_issue = last_issue;
    stat_o.pipe_busy  = rd_vld_q || mul_vld_q;
    stat_o.clr_last   = clr_last;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/matrix_multiply_with_empty_cells.sv */
// top level of the integer matrix multiply block with empty-cell tracking
// Usage:
//   slave stream s_axis: one request per beat; tuser holds the kind (write a,
//   write b, product, clear), tdata holds row, col and value.
//   master stream m_axis: one result per product request; tdata holds out_row,
//   out_col and product, tuser holds empty_cell and status.
//   config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (a_rows,
//   a_cols, b_rows, b_cols); write only while no request is in flight.
// Sequencing:
//   a cell write goes from accept through the decode state back to ready.
//   a clear sweeps both stores one cell per cycle.
//   a product request goes through decode, issue (inner = a_cols limited
//   to MAX_DIM steps), drain and result, or from decode straight to result
//   if rejected or inner is zero; one multiply-accumulate unit and one read
//   port per store serve it. Reset: control and config registers go to zero
//   and both stores are swept to empty with s_axis_tready low.
// Stall: a result waits in the output register; the next request is accepted
//   meanwhile, and a following product waits until that register is free.
`default_nettype none

module matrix_multiply_with_empty_cells #(
  parameter int unsigned MAX_DIM = mmec_pkg::MAX_DIM_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config write port
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [4:0]  cfg_data_i,
  // request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // row [3:0], col [7:4], value [39:8]
  input  wire  [1:0]  s_axis_tuser,   // kind [1:0]
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_row [3:0], out_col [7:4], product [39:8]
  output logic [2:0]  m_axis_tuser    // empty_cell [0], status [2:1]
);

  mmec_pkg::ctrl_cmd_t cmd;
  mmec_pkg::dp_stat_t  stat;

  logic [mmec_pkg::IDX_W-1:0]  out_row, out_col;
  logic [mmec_pkg::VAL_W-1:0]  out_product;
  logic                        out_empty;
  logic [mmec_pkg::STAT_W-1:0] out_status;

  // sequencer
  mmec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores and arithmetic
  mmec_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_kind_i     (s_axis_tuser),
    .in_row_i      (s_axis_tdata[3:0]),
    .in_col_i      (s_axis_tdata[7:4]),
    .in_value_i    (s_axis_tdata[39:8]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_product_o (out_product),
    .out_empty_o   (out_empty),
    .out_status_o  (out_status)
  );

  // result packing
  assign m_axis_tdata = {out_product, out_col, out_row};
  assign m_axis_tuser = {out_status, out_empty};

`ifndef SYNTH
  // no new request while the multiply pipeline still holds operands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.pipe_busy)
    else $error("request accepted with busy multiply pipeline");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote an untaken result");

  // clear sweep and cell writes never share the store write port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr_step && (cmd.write || cmd.issue || s_axis_tready)))
    else $error("clear sweep overlapped other store activity");

  // a loaded result becomes visible on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
